/* src/mwsn_pkg.sv */
// Shared constants, types and codes for the terrain map normal block.
`timescale 1ns / 1ps
package mwsn_pkg;
  localparam int MapWidth  = 512;
  localparam int MapHeight = 512;
  localparam int MaxRadius = 15;
  localparam int XW   = $clog2(MapWidth);
  localparam int YW   = $clog2(MapHeight);
  localparam int AW   = XW + YW;
  localparam int MapDepth = MapWidth * MapHeight;
  // 16 clear steps per cycle would need a wide port; sweep one entry per cycle
  localparam int SumW = 16;   // |sum| <= 31*31*15 < 2^15
  localparam int TotW = 2 * SumW;
  localparam int QW   = 30;   // a^2/total * 2^28 <= 2^28, plus margin

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_NORMAL = 2'd1,
    OP_EMPTY = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic              start;
    logic signed [SumW-1:0] s;
    logic [TotW-1:0]   total;
  } norm_req_t;

  typedef struct packed {
    logic              done;
    logic signed [15:0] m;
  } norm_rsp_t;
endpackage

/* src/mwsn_map_ram.sv */
// One-bit pixel map memory, one port, registered read.
`timescale 1ns / 1ps
module mwsn_map_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [mwsn_pkg::AW-1:0]     addr,
  input  logic                        wdata,
  output logic                        rdata
);
  import mwsn_pkg::*;
  logic mem [MapDepth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* src/mwsn_norm.sv */
// Normal component unit: long division a^2/total to 28 fraction bits, then isqrt.
`timescale 1ns / 1ps
module mwsn_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  mwsn_pkg::norm_req_t   req,
  output mwsn_pkg::norm_rsp_t   rsp
);
  import mwsn_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ   = 4'b0010,
    S_DIV  = 4'b0100,
    S_SQRT = 4'b1000
  } st_t;
  st_t st;
  logic neg;
  logic [SumW-1:0] a;
  logic [TotW-1:0] tot;
  logic [TotW:0] rem;
  logic [TotW-1:0] num;
  logic [QW-1:0] q;
  logic [5:0] cnt;
  logic [QW+1:0] n, res, bit_r;
  logic [TotW:0] rem_sh;
  logic [QW+1:0] trial;

  assign rem_sh = {rem[TotW-1:0], num[TotW-1]};
  assign trial = res + bit_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (req.start) begin
            neg <= req.s[SumW-1];
            a   <= req.s[SumW-1] ? SumW'(-req.s) : req.s;
            tot <= req.total;
            st  <= S_SQ;
          end
        end
        S_SQ: begin
          num <= TotW'(a * a);
          rem <= '0;
          q   <= '0;
          cnt <= 6'(TotW + 28);
          st  <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle (num then zeros)
          if (rem_sh >= {1'b0, tot}) begin
            rem <= rem_sh - {1'b0, tot};
            q   <= {q[QW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[QW-2:0], 1'b0};
          end
          num <= {num[TotW-2:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            st <= S_SQRT;
            res <= '0;
            bit_r <= (QW+2)'(1) << 30;
          end
        end
        S_SQRT: begin
          if (cnt == 6'd0) begin
            n <= {2'b00, q};
            cnt <= 6'd1;
          end else if (bit_r == '0) begin
            rsp.done <= 1'b1;
            rsp.m <= neg ? -16'(res) : 16'(res);
            st <= S_IDLE;
          end else begin
            if (n >= trial) begin
              n <= n - trial;
              res <= (res >> 1) + bit_r;
            end else begin
              res <= res >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/mask_window_surface_normal_core.sv */
// Top level: map sequencer, window scan and result register.
//  channel | dir | handshake            | payload
//  s_axis  | in  | s_tvalid/s_tready    | op, x, y, radius, solid
//  m_axis  | out | m_tvalid/m_tready    | normal_x, normal_y, empty_res
// After reset a clear sweep writes every map entry.
// Normal query: one map read per window pixel, then the two normal units run in
// parallel when the sum is nonzero (60-step division, 16-step sqrt).
// One item in flight; s_tready is low until its result is taken or parked.
`timescale 1ns / 1ps
module mask_window_surface_normal_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // op[1:0], x[12:2], y[23:13], radius[27:24], solid[28]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // normal_x[15:0], normal_y[31:16], empty_res[32]
);
  import mwsn_pkg::*;
  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_LAST = 7'b0010000,
    S_NORM = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;
  st_t st;

  op_t op;
  logic signed [10:0] x, y;
  logic [3:0] rad;
  logic sol;
  logic signed [5:0] i, j, pi, pj;  // current and previous offset
  logic pvalid;
  logic signed [SumW-1:0] sx, sy;
  logic cout;
  logic [AW-1:0] clr_addr;

  logic we, wd, rd;
  logic [AW-1:0] addr;
  logic signed [12:0] px, py;
  logic pin, cin;
  logic [3:0] radc;
  logic signed [5:0] r6;
  logic signed [TotW-1:0] sq_x, sq_y;
  norm_req_t rqx, rqy;
  norm_rsp_t rsx, rsy;
  logic gotx, goty;
  logic signed [15:0] nx, ny;
  logic er;

  assign radc = (rad > 4'(MaxRadius)) ? 4'(MaxRadius) : rad;
  assign r6 = 6'(radc);
  assign px = 13'(x) + 13'(i);
  assign py = 13'(y) + 13'(j);
  assign pin = px >= 0 && px < MapWidth && py >= 0 && py < MapHeight;
  assign cin = x >= 0 && x < MapWidth && y >= 0 && y < MapHeight;

  always_comb begin
    we = 1'b0;
    wd = 1'b0;
    addr = AW'(py[YW-1:0]) * AW'(MapWidth) + AW'(px[XW-1:0]);
    if (st == S_CLR) begin
      we = 1'b1;
      addr = clr_addr;
    end else if (st == S_RD && op == OP_WRITE && cin) begin
      we = 1'b1;
      wd = sol;
    end
  end

  mwsn_map_ram u_ram (.clk(clk), .we(we), .addr(addr), .wdata(wd), .rdata(rd));

  assign sq_x = TotW'(sx * sx);
  assign sq_y = TotW'(sy * sy);
  assign rqx.start = (st == S_LAST) && !pvalid && (sx != 0 || sy != 0);
  assign rqx.s = sx;
  assign rqx.total = sq_x + sq_y;
  assign rqy.start = rqx.start;
  assign rqy.s = sy;
  assign rqy.total = rqx.total;

  mwsn_norm u_nx (.clk(clk), .rst(rst), .req(rqx), .rsp(rsx));
  mwsn_norm u_ny (.clk(clk), .rst(rst), .req(rqy), .rsp(rsy));

  assign s_tready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result is parked here so the next item can run while it waits
      if (st == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata <= {7'd0, er, ny, nx};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MapDepth - 1)) st <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op <= op_t'(s_tdata[1:0]);
            x <= s_tdata[12:2];
            y <= s_tdata[23:13];
            rad <= s_tdata[27:24];
            sol <= s_tdata[28];
            i <= '0;
            j <= '0;
            st <= S_RD;
          end
        end
        S_RD: begin
          nx <= '0; ny <= '0; er <= 1'b0;
          sx <= '0; sy <= '0;
          cout <= !cin;
          pvalid <= 1'b0;
          i <= -r6;
          j <= -r6;
          if (op == OP_NORMAL) st <= S_SCAN;
          else if (op == OP_EMPTY && cin) st <= S_LAST;
          else st <= S_OUT;
        end
        S_SCAN: begin
          // address issued this cycle; data of previous offset arrives now
          if (pvalid) begin
            if (rd) begin
              sx <= sx - SumW'(pi);
              sy <= sy - SumW'(pj);
            end else if (cout) begin
              sx <= sx + SumW'(pi);
              sy <= sy + SumW'(pj);
            end
          end
          pvalid <= pin;
          pi <= i;
          pj <= j;
          if (j == r6) begin
            j <= -r6;
            if (i == r6) st <= S_LAST;
            else i <= i + 6'sd1;
          end else begin
            j <= j + 6'sd1;
          end
        end
        S_LAST: begin
          if (op == OP_EMPTY) begin
            er <= !rd;
            st <= S_OUT;
          end else if (pvalid) begin
            pvalid <= 1'b0;
            if (rd) begin
              sx <= sx - SumW'(pi);
              sy <= sy - SumW'(pj);
            end else if (cout) begin
              sx <= sx + SumW'(pi);
              sy <= sy + SumW'(pj);
            end
          end else if (rqx.start) begin
            gotx <= 1'b0;
            goty <= 1'b0;
            st <= S_NORM;
          end else begin
            st <= S_OUT;
          end
        end
        S_NORM: begin
          if (rsx.done) begin nx <= rsx.m; gotx <= 1'b1; end
          if (rsy.done) begin ny <= rsy.m; goty <= 1'b1; end
          if ((gotx || rsx.done) && (goty || rsy.done)) st <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

/* tb/tb.sv */
// Testbench for the terrain map normal core: predicted results checked item by item.
`timescale 1ns / 1ps
module tb;
  import mwsn_pkg::*;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               emp;
  } map_result_t;

  class normal_scoreboard;
    bit          map_bits [MapDepth];
    map_result_t pending[$];
    int          errors;
    int          checked;

    function automatic bit in_map(int px, int py);
      return px >= 0 && px < MapWidth && py >= 0 && py < MapHeight;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // trunc(s * 2^14 / sqrt(total)) via sqrt(s^2 * 2^28 / total)
    function automatic int unit_comp(longint s, longint unsigned total);
      longint unsigned a, q, r;
      int m;
      a = (s < 0) ? -s : s;
      q = (a * a) / total;
      r = (a * a) % total;
      for (int k = 0; k < 28; k++) begin
        r <<= 1;
        q <<= 1;
        if (r >= total) begin
          r -= total;
          q |= 1;
        end
      end
      m = int'(int_sqrt(q));
      return (s < 0) ? -m : m;
    endfunction

    function void note_item(op_t op, int x, int y, int rad, bit solid);
      map_result_t e;
      longint sx, sy;
      longint unsigned total;
      bit centre_out;
      e = '{0, 0, 0};
      case (op)
        OP_WRITE: if (in_map(x, y)) map_bits[y * MapWidth + x] = solid;
        OP_NORMAL: begin
          sx = 0;
          sy = 0;
          centre_out = !in_map(x, y);
          if (rad > MaxRadius) rad = MaxRadius;
          for (int i = -rad; i <= rad; i++)
            for (int j = -rad; j <= rad; j++) begin
              if (!in_map(x + i, y + j)) continue;
              if (map_bits[(y + j) * MapWidth + x + i]) begin
                sx -= i;
                sy -= j;
              end else if (centre_out) begin
                sx += i;
                sy += j;
              end
            end
          total = sx * sx + sy * sy;
          if (total != 0) begin
            e.nx = unit_comp(sx, total);
            e.ny = unit_comp(sy, total);
          end
        end
        OP_EMPTY: e.emp = in_map(x, y) && !map_bits[y * MapWidth + x];
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(logic [39:0] d);
      map_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[15:0] !== e.nx) begin
        $error("normal_x expected %0d got %0d", e.nx, $signed(d[15:0]));
        errors++;
      end
      if (d[31:16] !== e.ny) begin
        $error("normal_y expected %0d got %0d", e.ny, $signed(d[31:16]));
        errors++;
      end
      if (d[32] !== e.emp) begin
        $error("empty_res expected %0b got %0b", e.emp, d[32]);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [31:0] s_tdata;
  logic [39:0] m_tdata;
  normal_scoreboard sb;
  int          sent;
  bit          calm;
  longint      cycles;

  localparam longint CycleLimit = 64'd4_000_000;

  mask_window_surface_normal_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // sends one item; an idle burst may precede it; tvalid stays up between items
  task automatic send_item(op_t op, int x, int y, int rad, bit solid);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tdata <= {3'b0, solid, rad[3:0], y[10:0], x[10:0], op};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, x, y, rad & 15, solid);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    m_tready = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      @(negedge clk);
    end
  end

  // stamps a filled blob of solid pixels
  task automatic paint_blob(int cx, int cy, int r);
    for (int i = -r; i <= r; i++)
      for (int j = -r; j <= r; j++)
        if (i * i + j * j <= r * r) send_item(OP_WRITE, cx + i, cy + j, 0, 1);
  endtask

  initial begin
    int x, y, kind, wait_cnt;
    op_t op;
    sb = new();
    sent = 0;
    calm = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, every op, out-of-map cases, unused code, big radius
    send_item(OP_NORMAL, 100, 100, 5, 0);
    send_item(OP_EMPTY, 0, 0, 0, 0);
    send_item(OP_WRITE, 0, 0, 0, 1);
    send_item(OP_EMPTY, 0, 0, 0, 0);
    send_item(OP_WRITE, 511, 511, 15, 1);
    send_item(OP_WRITE, -1024, 1023, 0, 1);
    send_item(OP_WRITE, 512, 3, 0, 1);
    send_item(OP_EMPTY, -1, 5, 0, 1);
    send_item(OP_EMPTY, 511, 512, 0, 0);
    send_item(OP_NORMAL, 0, 0, 15, 0);
    send_item(OP_NORMAL, 511, 511, 0, 1);
    send_item(OP_NORMAL, -3, -2, 6, 0);
    send_item(OP_NORMAL, 514, 510, 4, 0);
    send_item(OP_NORMAL, 1023, -1024, 15, 1);
    send_item(OP_NONE, 1, 1, 0, 1);
    send_item(OP_EMPTY, 1, 1, 0, 0);
    send_item(OP_WRITE, 0, 0, 0, 0);
    send_item(OP_NORMAL, 1, 1, 2, 0);
    paint_blob(200, 200, 2);

    // random: terrain writes plus queries around them, some noise
    while (sent < 620) begin
      if (sent > 540) calm = 1;
      x = $urandom_range(0, 40) + 180;
      y = $urandom_range(0, 40) + 180;
      kind = $urandom_range(0, 9);
      if (kind < 4)
        send_item(OP_WRITE, x, y, $urandom, $urandom_range(0, 3) != 0);
      else if (kind < 7)
        send_item(OP_NORMAL, x, y, $urandom_range(0, 8) == 0 ? 15 : $urandom_range(0, 6),
                  $urandom);
      else if (kind < 9)
        send_item(OP_EMPTY, x, y, $urandom, $urandom);
      else begin
        op = op_t'($urandom_range(0, 3));
        x = $signed(11'($urandom));
        y = $signed(11'($urandom));
        if ($urandom_range(0, 1)) begin
          x = $urandom_range(0, 3) == 0 ? -1 - $urandom_range(0, 2) : 509 + $urandom_range(0, 5);
        end
        send_item(op, x, y, $urandom, $urandom);
      end
    end
    s_tvalid <= 0;

    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d items (writes, normal and empty queries, off-map and unused codes),",
             sent);
    $display("%0d results compared against the predicted map behavior.", sb.checked);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

/* sim.f */
src/mwsn_pkg.sv
src/mwsn_map_ram.sv
src/mwsn_norm.sv
src/mask_window_surface_normal_core.sv
tb/tb.sv
